// ===== design/tcgr_pkg.sv =====
package tcgr_pkg;

  // Grid and font geometry
  localparam int COL_LIMIT      = 256;
  localparam int MAX_ROWS       = 128;
  localparam int GLYPH_COUNT    = 96;
  localparam int MAX_GLYPH_ROWS = 16;
  localparam int CHAR_WIDTH     = 8;

  localparam int FONT_DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);
  localparam int GLYPH_W    = $clog2(GLYPH_COUNT);
  localparam int GROW_W     = $clog2(MAX_GLYPH_ROWS);
  localparam int HEIGHT_W   = $clog2(MAX_GLYPH_ROWS + 1);

  // Character codes
  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd127;
  localparam logic [7:0] SUBST_CODE = 8'd63;
  localparam logic [7:0] ALPHA      = 8'd255;

  // Input kinds carried on tuser
  localparam logic OP_RENDER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_H  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COL  = 3'd7;
  localparam int CFG_DATA_W = 48;

  // Stream widths
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 280;
  localparam int PIX_W    = 32;
  localparam int COORD_W  = 11;

  // Command queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified command from front to back
  typedef struct packed {
    logic                is_load;
    logic [GLYPH_W-1:0]  glyph;
    logic [GROW_W-1:0]   load_row;
    logic [7:0]          load_bits;
    logic                blank;
    logic [23:0]         fg;
    logic [23:0]         bg;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [HEIGHT_W-1:0] height;
  } cmd_t;

endpackage

// ===== design/tcgr_ram.sv =====
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds without rd_en
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/tcgr_front.sv =====
module tcgr_front
  import tcgr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,
  input  logic                  s_tuser,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd
);

  logic [47:0] pal_a, pal_b, pal_c, pal_d;
  logic [8:0]  grid_columns;
  logic [7:0]  grid_rows;
  logic [4:0]  glyph_height;
  logic [8:0]  output_columns;

  logic [7:0] cell_column;
  logic [6:0] cell_row;
  logic [7:0] char_code;
  logic [2:0] fore_index, back_index;
  logic [3:0] load_row;
  logic [7:0] load_bits;

  logic [8:0]          gc, lim;
  logic [7:0]          gr;
  logic [HEIGHT_W-1:0] h;
  logic                render_ok, load_ok;
  logic [7:0]          ch_eff, glyph_full;
  logic [11:0]         y_prod;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_a          <= '0;
      pal_b          <= '0;
      pal_c          <= '0;
      pal_d          <= '0;
      grid_columns   <= 9'd80;
      grid_rows      <= 8'd25;
      glyph_height   <= 5'd8;
      output_columns <= 9'd80;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAL_A:    pal_a          <= cfg_data;
        REG_PAL_B:    pal_b          <= cfg_data;
        REG_PAL_C:    pal_c          <= cfg_data;
        REG_PAL_D:    pal_d          <= cfg_data;
        REG_GRID_COL: grid_columns   <= cfg_data[8:0];
        REG_GRID_ROW: grid_rows      <= cfg_data[7:0];
        REG_GLYPH_H:  glyph_height   <= cfg_data[4:0];
        REG_OUT_COL:  output_columns <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Palette lookup: pair by upper index bits, half by the low bit
  function automatic logic [23:0] colour_of(input logic [2:0] idx,
                                            input logic [47:0] a, input logic [47:0] b,
                                            input logic [47:0] c, input logic [47:0] d);
    logic [47:0] pair;
    case (idx[2:1])
      2'd0:    pair = a;
      2'd1:    pair = b;
      2'd2:    pair = c;
      default: pair = d;
    endcase
    return idx[0] ? pair[47:24] : pair[23:0];
  endfunction

  // Unpack the input transfer
  assign cell_column = s_tdata[7:0];
  assign cell_row    = s_tdata[14:8];
  assign char_code   = s_tdata[22:15];
  assign fore_index  = s_tdata[25:23];
  assign back_index  = s_tdata[28:26];
  assign load_row    = s_tdata[32:29];
  assign load_bits   = s_tdata[40:33];

  // Grid limits and glyph height, saturated
  always_comb begin
    gc  = (grid_columns > 9'(COL_LIMIT)) ? 9'(COL_LIMIT) : grid_columns;
    lim = (gc < output_columns) ? gc : output_columns;
    gr  = (grid_rows > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : grid_rows;
    h   = (glyph_height > 5'(MAX_GLYPH_ROWS)) ? HEIGHT_W'(MAX_GLYPH_ROWS)
                                              : HEIGHT_W'(glyph_height);
    render_ok = ({1'b0, cell_column} < lim) && ({1'b0, cell_row} < gr) && (h != '0);
    load_ok   = (char_code >= FIRST_CODE) && (char_code <= LAST_CODE);
    ch_eff    = load_ok ? char_code : SUBST_CODE;
    glyph_full = ch_eff - FIRST_CODE;
    y_prod    = 12'(cell_row) * 12'(h);
  end

  // Classified command into the queue
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready && ((s_tuser == OP_LOAD) ? load_ok : render_ok);

  always_comb begin
    q_cmd.is_load   = (s_tuser == OP_LOAD);
    q_cmd.glyph     = glyph_full[GLYPH_W-1:0];
    q_cmd.load_row  = load_row;
    q_cmd.load_bits = load_bits;
    q_cmd.blank     = (glyph_full == 8'd0);
    q_cmd.fg        = colour_of(fore_index, pal_a, pal_b, pal_c, pal_d);
    q_cmd.bg        = colour_of(back_index, pal_a, pal_b, pal_c, pal_d);
    q_cmd.x         = {cell_column, 3'b000};
    q_cmd.y         = y_prod[COORD_W-1:0];
    q_cmd.height    = h;
  end

endmodule

// ===== design/tcgr_queue.sv =====
module tcgr_queue
  import tcgr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/tcgr_back.sv =====
module tcgr_back
  import tcgr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  cmd_t                head_cmd,
  output logic                pop,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tlast
);

  cmd_t                cmd;
  logic                busy;
  logic [HEIGHT_W-1:0] rd_row;
  logic                pend;
  logic [GROW_W-1:0]   pend_row;

  logic               wr_en, rd_en, issue, move;
  logic [FONT_AW-1:0] wr_addr, rd_addr;
  logic [7:0]         rd_data, bits;

  logic [COORD_W-1:0]      out_x, out_y;
  logic [8*PIX_W-1:0]      out_pix, pix_next;
  logic                    out_last;

  // Font store
  tcgr_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (head_cmd.load_bits),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Take a command only when no row is in flight
  assign pop     = head_valid && !busy && !pend;
  assign wr_en   = pop && head_cmd.is_load;
  assign wr_addr = {head_cmd.glyph, head_cmd.load_row};

  // Row read and hand-off to the output register
  assign move    = pend && (!m_tvalid || m_tready);
  assign issue   = busy && (!pend || move);
  assign rd_en   = issue;
  assign rd_addr = {cmd.glyph, rd_row[GROW_W-1:0]};

  always_ff @(posedge clk) begin
    if (pop && !head_cmd.is_load) begin
      cmd <= head_cmd;
    end
    if (issue) begin
      pend_row <= rd_row[GROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      rd_row <= '0;
      pend   <= 1'b0;
    end else begin
      if (pop && !head_cmd.is_load) begin
        busy   <= 1'b1;
        rd_row <= '0;
      end else if (issue) begin
        rd_row <= rd_row + 1'b1;
        if (rd_row + 1'b1 == cmd.height) begin
          busy <= 1'b0;
        end
      end
      if (issue) begin
        pend <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end
    end
  end

  // Pixel expansion: foreground where the glyph bit is set
  always_comb begin
    bits = cmd.blank ? 8'd0 : rd_data;
    for (int k = 0; k < CHAR_WIDTH; k++) begin
      pix_next[k*PIX_W +: PIX_W] = {ALPHA, bits[k] ? cmd.fg : cmd.bg};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (move) begin
      out_x    <= cmd.x;
      out_y    <= cmd.y + COORD_W'(pend_row);
      out_pix  <= pix_next;
      out_last <= (HEIGHT_W'(pend_row) + 1'b1 == cmd.height);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {2'b00, out_pix, out_y, out_x};
  assign m_tlast = out_last;

endmodule

// ===== design/text_cell_glyph_renderer_top.sv =====
// Text-mode character generator.
// Input stream s_*: tuser is the opcode (0 render a cell, 1 load a font row).
// A load writes one 8-bit glyph row for codes 32..127; other codes are dropped.
// A render names a cell and two palette indices and yields one output transfer
// per glyph row: eight 32-bit pixels (alpha 0xFF, R, G, B), foreground where
// the glyph bit is set; tlast marks the final row. Codes outside 32..127 draw
// '?', space always draws background, and cells off the grid yield nothing.
// Config port cfg_*: register index and 48-bit data, always ready; write only
// while the block is idle.
// The first row of a cell passes through the queue entry, the command register,
// the font memory read and the output register, in that order. A cell needs one
// font memory read per row plus the last row's hand-off before the next command
// is taken; a load is a single font memory write and leaves the block idle.
// A two-entry command queue decouples input from rendering, so input is taken
// while a finished row waits. When the receiver stalls, the output row holds
// and one more row waits at the memory output, then the queue fills and
// s_tready drops. Reset empties the queue and restores the default grid
// (80 x 25, height 8) and a black palette; font contents are undefined.
module text_cell_glyph_renderer_top
  import tcgr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // cell_column, cell_row, char_code, fore_index, back_index, load_row, load_bits
  input  logic [S_DATA_W-1:0]   s_tdata,
  // opcode
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pixel_x, pixel_y, pixels_01, pixels_23, pixels_45, pixels_67
  output logic [M_DATA_W-1:0]   m_tdata,
  output logic                  m_tlast
);

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_in, q_head;

  tcgr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  tcgr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  tcgr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

// ===== design/tcgr_checker.sv =====
module tcgr_checker
  import tcgr_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tlast
);

  // Nothing leaves in the cycle after reset
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // A stalled output row holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // Every pixel is opaque
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[53:46] == ALPHA) && (m_tdata[85:78] == ALPHA) &&
                 (m_tdata[117:110] == ALPHA) && (m_tdata[149:142] == ALPHA) &&
                 (m_tdata[181:174] == ALPHA) && (m_tdata[213:206] == ALPHA) &&
                 (m_tdata[245:238] == ALPHA) && (m_tdata[277:270] == ALPHA))
    else $error("pixel alpha not 0xFF");

  // Pixel x is cell aligned and padding stays clear
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] == 3'd0) && (m_tdata[279:278] == 2'd0))
    else $error("bad pixel_x alignment or padding");

  // Handshake lines are always known once out of reset
  assert property (@(posedge clk) disable iff (rst)
    !$isunknown({s_tvalid, s_tready, m_tvalid, m_tready}))
    else $error("unknown handshake level");

endmodule

bind text_cell_glyph_renderer_top tcgr_checker u_tcgr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
